/* rtl/fcp_pkg.sv */
// Shared types and constants for the float RGBA to Cineon log packer.
// No dependencies; every other file of the block imports this package.
package fcp_pkg;

  localparam logic [31:0] LOG_B_Q28       = 32'd2898499;
  localparam logic [31:0] ONE_MINUS_B_Q28 = 32'd265536957;
  localparam logic [22:0] LOG_K_Q16       = 23'd5918491;
  localparam logic [9:0]  CODE_OFFSET     = 10'd685;
  localparam logic [9:0]  CODE_MAX        = 10'd1023;
  localparam logic [9:0]  CODE_LOW        = 10'd95;
  localparam logic [11:0] ALPHA_SCALE     = 12'd2559;
  localparam logic [15:0] DIV10_RECIP     = 16'd52429;
  localparam logic [13:0] WIDTH_RESET     = 14'd1;
  localparam int          RED_SHIFT       = 22;
  localparam int          GREEN_SHIFT     = 12;
  localparam int          BLUE_SHIFT      = 2;

  typedef struct packed {
    logic [31:0] red_bits;
    logic [31:0] green_bits;
    logic [31:0] blue_bits;
    logic [31:0] alpha_bits;
    logic        frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [31:0] color_word;
    logic [7:0]  alpha_byte;
    logic [25:0] pixel_index;
    logic        row_end;
  } pix_out_t;

  // Classified pixel as it waits between the front and the back.
  typedef struct packed {
    logic [2:0][31:0] xq;
    logic [2:0]       low;
    logic             a_zero;
    logic             a_sat;
    logic [23:0]      a_m;
    logic [5:0]       a_s;
    logic [25:0]      pixel_index;
    logic             row_end;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALPHA,
    ST_DIVA,
    ST_XMUL,
    ST_NORM,
    ST_SQR,
    ST_SCALE,
    ST_EMIT
  } back_state_t;

endpackage

/* rtl/fcp_front.sv */
// Front end: accepts pixels, keeps the row/column counters and the width
// register, and classifies each channel into a queue entry. Uses fcp_pkg.
module fcp_front #(
  parameter int MAX_WIDTH  = 8192,
  parameter int MAX_HEIGHT = 8192
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [13:0]     cfg_wdata,
  input  logic            accept,
  input  fcp_pkg::pix_in_t pix,
  output fcp_pkg::entry_t  entry
);
  import fcp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [13:0]   width_r;
  logic [CW-1:0] col_r, col_nxt, col;
  logic [RW-1:0] row_r, row_nxt, row;
  logic [WW-1:0] w_eff;
  logic [33:0]   idx;
  logic          last;

  function automatic logic [31:0] to_q28(input logic [31:0] f);
    logic [7:0]  ex;
    logic [31:0] m;
    logic [7:0]  r;
    ex = f[30:23];
    m  = {8'b0, 1'b1, f[22:0]};
    r  = 8'd122 - ex;
    if (ex > 8'd130) to_q28 = '1;
    else if (ex >= 8'd122) to_q28 = m << (ex - 8'd122);
    else if (r >= 8'd32) to_q28 = '0;
    else to_q28 = m >> r[4:0];
  endfunction

  function automatic logic is_low(input logic [31:0] f);
    is_low = f[31] || (f[30:0] == 31'd0) || ((f[30:23] == 8'hFF) && (f[22:0] != 23'd0));
  endfunction

  always_comb begin
    logic [16:0] wx;
    wx = {3'b0, width_r};
    if (width_r == 14'd0) w_eff = WW'(1);
    else if (wx > 17'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(wx);
  end

  assign col  = pix.frame_start ? '0 : col_r;
  assign row  = pix.frame_start ? '0 : row_r;
  assign last = {1'b0, 17'(col)} >= (18'(w_eff) - 18'd1);
  assign idx  = 34'(row) * 34'(w_eff) + 34'(col);

  always_comb begin
    if (last) begin
      col_nxt = '0;
      row_nxt = (row == RW'(MAX_HEIGHT - 1)) ? '0 : row + RW'(1);
    end else begin
      col_nxt = col + CW'(1);
      row_nxt = row;
    end
  end

  always_comb begin
    logic [7:0] aex;
    logic [8:0] s;
    aex = pix.alpha_bits[30:23];
    s   = (aex == 8'd0) ? 9'd149 : (9'd150 - {1'b0, aex});
    entry.xq[0]       = to_q28(pix.red_bits);
    entry.xq[1]       = to_q28(pix.green_bits);
    entry.xq[2]       = to_q28(pix.blue_bits);
    entry.low[0]      = is_low(pix.red_bits);
    entry.low[1]      = is_low(pix.green_bits);
    entry.low[2]      = is_low(pix.blue_bits);
    entry.a_sat       = aex >= 8'd127;
    entry.a_zero      = is_low(pix.alpha_bits) || (!entry.a_sat && s >= 9'd40);
    entry.a_m         = {aex != 8'd0, pix.alpha_bits[22:0]};
    entry.a_s         = s[5:0];
    entry.pixel_index = idx[25:0];
    entry.row_end     = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      if (cfg_we) width_r <= cfg_wdata;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

endmodule

/* rtl/fcp_queue.sv */
// Two-entry queue of classified pixels between the front and the back.
// Uses fcp_pkg for the entry and status types.
module fcp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  fcp_pkg::entry_t      wdata,
  input  logic                 pop,
  output fcp_pkg::entry_t      rdata,
  output fcp_pkg::queue_stat_t stat
);
  import fcp_pkg::*;

  entry_t     mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.full  = cnt_r == 2'd2;
  assign stat.empty = cnt_r == 2'd0;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

/* rtl/fcp_back.sv */
// Back end: sequencer that scales alpha and works the three log codes one
// channel at a time with one shared squarer. Uses fcp_pkg.
module fcp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fcp_pkg::entry_t      head,
  input  fcp_pkg::queue_stat_t qstat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fcp_pkg::pix_out_t    out_data
);
  import fcp_pkg::*;

  back_state_t     state_r, state_nxt;
  entry_t          ent_r;
  logic [1:0]      ch_r;
  logic [11:0]     a_r;
  logic [7:0]      alpha_r;
  logic [31:0]     z_r;
  logic [4:0]      p_r;
  logic [15:0]     frac_r;
  logic [3:0]      cnt_r;
  logic [2:0][9:0] code_r;
  logic            out_valid_r;
  pix_out_t        out_data_r;
  logic            load_out;

  logic [35:0] aprod;
  logic [27:0] qprod;
  logic [59:0] yprod;
  logic [32:0] ysum;
  logic [63:0] sq;
  logic [21:0] lg, mag;
  logic [44:0] kprod;
  logic [14:0] code_s;
  logic [9:0]  code_c;

  assign aprod = 36'(ent_r.a_m) * 36'(ALPHA_SCALE);
  assign qprod = 28'(a_r) * 28'(DIV10_RECIP);
  assign yprod = 60'(ent_r.xq[ch_r]) * 60'(ONE_MINUS_B_Q28);
  assign ysum  = 33'(LOG_B_Q28) + 33'(yprod[59:28]);
  assign sq    = 64'(z_r) * 64'(z_r);
  assign lg    = {6'(p_r) - 6'd28, 16'b0} + {6'b0, frac_r};
  assign mag   = lg[21] ? (22'd0 - lg) : lg;
  assign kprod = 45'(mag) * 45'(LOG_K_Q16);

  always_comb begin
    if (lg[21]) code_s = 15'(CODE_OFFSET) - 15'(kprod[44:32]);
    else code_s = 15'(CODE_OFFSET) + 15'(kprod[44:32]);
    if (code_s[14]) code_c = 10'd0;
    else if (code_s > 15'(CODE_MAX)) code_c = CODE_MAX;
    else code_c = code_s[9:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (!qstat.empty) state_nxt = ST_ALPHA;
      ST_ALPHA: state_nxt = ST_DIVA;
      ST_DIVA:  state_nxt = ST_XMUL;
      ST_XMUL: begin
        if (!ent_r.low[ch_r]) state_nxt = ST_NORM;
        else if (ch_r == 2'd2) state_nxt = ST_EMIT;
      end
      ST_NORM:  if (z_r[31]) state_nxt = ST_SQR;
      ST_SQR:   if (cnt_r == 4'd15) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = (ch_r == 2'd2) ? ST_EMIT : ST_XMUL;
      ST_EMIT:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: pop = !qstat.empty;
      ST_EMIT: load_out = !out_valid_r || !out_stall;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        ent_r <= head;
        ch_r  <= 2'd0;
      end
      ST_ALPHA: a_r <= 12'(aprod >> ent_r.a_s);
      ST_DIVA: begin
        if (ent_r.a_zero) alpha_r <= 8'd0;
        else if (ent_r.a_sat || qprod[27:19] > 9'd255) alpha_r <= 8'd255;
        else alpha_r <= qprod[26:19];
      end
      ST_XMUL: begin
        z_r    <= ysum[31:0];
        p_r    <= 5'd31;
        cnt_r  <= 4'd0;
        frac_r <= 16'd0;
        if (ent_r.low[ch_r]) begin
          code_r[ch_r] <= CODE_LOW;
          ch_r         <= ch_r + 2'd1;
        end
      end
      ST_NORM: begin
        if (!z_r[31]) begin
          z_r <= z_r << 1;
          p_r <= p_r - 5'd1;
        end
      end
      ST_SQR: begin
        // The square of the Q1.31 mantissa is at least 2 when bit 63 is set.
        z_r    <= sq[63] ? sq[63:32] : sq[62:31];
        frac_r <= {frac_r[14:0], sq[63]};
        cnt_r  <= cnt_r + 4'd1;
      end
      ST_SCALE: begin
        code_r[ch_r] <= code_c;
        ch_r         <= ch_r + 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.color_word  <= (32'(code_r[0]) << RED_SHIFT) |
                                (32'(code_r[1]) << GREEN_SHIFT) |
                                (32'(code_r[2]) << BLUE_SHIFT);
      out_data_r.alpha_byte  <= alpha_r;
      out_data_r.pixel_index <= ent_r.pixel_index;
      out_data_r.row_end     <= ent_r.row_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/float_rgba_to_cineon_packer.sv */
// Top level of the float RGBA to Cineon log packer: front, queue and back.
// Depends on fcp_pkg, fcp_front, fcp_queue and fcp_back.
//
//   port group   direction  handshake           payload
//   in_*         input      in_valid/in_stall   fcp_pkg::pix_in_t
//   out_*        output     out_valid/out_stall fcp_pkg::pix_out_t
//   cfg_*        input      cfg_we              14-bit image width
//
// In the back end a pixel passes alpha scaling, each color in turn and an emit
// step. A color above zero is normalized by a left shift of at most 10 places,
// squared once per fraction bit and scaled; a color at or below zero, or NaN,
// takes the low code. One shared 32x32 squarer steps the log one bit per cycle.
// The queue holds two pixels, so the front accepts while the back works.
// Reset is synchronous and active low; it clears counters and queue and sets
// the width to one.
module float_rgba_to_cineon_packer #(
  parameter int MAX_WIDTH  = 8192,
  parameter int MAX_HEIGHT = 8192
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fcp_pkg::pix_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fcp_pkg::pix_out_t out_data,
  input  logic              cfg_we,
  input  logic [13:0]       cfg_wdata
);
  import fcp_pkg::*;

  entry_t      front_entry, head;
  queue_stat_t qstat;
  logic        accept, pop;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !qstat.full;

  fcp_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .accept, .pix(in_data), .entry(front_entry)
  );

  fcp_queue u_queue (
    .clk, .rst_n, .push(accept), .wdata(front_entry), .pop, .rdata(head), .stat(qstat)
  );

  fcp_back u_back (
    .clk, .rst_n, .head, .qstat, .pop, .out_valid, .out_stall, .out_data
  );

  a_stat_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty)) else $error("queue both full and empty");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty) else $error("pop from empty queue");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule
